FILE: rtl/core/sinetg_pkg.sv
`default_nettype none

package sinetg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int ROM_SIZE        = (1 << TABLE_ADDR_BITS) + 1;
  localparam int MAG_W           = 31;
  localparam int SAMPLE_W        = 32;
  localparam int PROD_W          = 2 * MAG_W;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef logic [PHASE_BITS-1:0]      phase_t;
  typedef logic [TABLE_ADDR_BITS:0]   rom_addr_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic [ROM_SIZE-1:0][MAG_W-1:0] sine_rom_t;

  // Register map of the configuration port
  typedef enum logic [1:0] {
    CFG_PHASE_STEP    = 2'd0,
    CFG_SAMPLE_BYTES  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  // One queued frame request: quarter-wave address and sign
  typedef struct packed {
    rom_addr_t addr;
    logic      neg;
  } frame_req_t;

  // (a*b) >> 62, low 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring long division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine in Q1.30 from a Q62 Taylor series, evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] nn;
    logic [63:0] dv;
    rom  = '0;
    frac = HALF_PI_Q62 & ((64'd1 << TABLE_ADDR_BITS) - 64'd1);
    for (int n = 0; n < ROM_SIZE; n++) begin
      nn   = 64'(n);
      x    = (HALF_PI_Q62 >> TABLE_ADDR_BITS) * nn + ((frac * nn) >> TABLE_ADDR_BITS);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 12; k++) begin
        dv   = 64'((2 * k) * (2 * k + 1));
        term = udiv64(mul_q62(term, x2), dv);
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + (64'd1 << 31)) >> 32;
      if (r > (64'd1 << 30)) begin
        r = 64'd1 << 30;
      end
      rom[n] = r[MAG_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: rtl/core/sinetg_front.sv
`default_nettype none

module sinetg_front
  import sinetg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_restart,
  input  wire logic [31:0] phase_step,
  input  wire logic       q_full,
  output logic            q_push,
  output frame_req_t      q_wdata
);

  phase_t phase_acc_r;
  phase_t phase_acc_nxt;
  phase_t phase_cur;
  logic [TABLE_ADDR_BITS+1:0] top;
  logic [TABLE_ADDR_BITS-1:0] idx;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    phase_cur = in_restart ? '0 : phase_acc_r;
    top       = phase_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
    idx       = top[TABLE_ADDR_BITS-1:0];
    // odd quadrants run the table backwards
    if (top[TABLE_ADDR_BITS]) begin
      q_wdata.addr = (rom_addr_t'(1) << TABLE_ADDR_BITS) - {1'b0, idx};
    end else begin
      q_wdata.addr = {1'b0, idx};
    end
    q_wdata.neg   = top[TABLE_ADDR_BITS+1];
    phase_acc_nxt = phase_acc_r;
    if (q_push) begin
      phase_acc_nxt = phase_cur + phase_t'(phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else begin
      phase_acc_r <= phase_acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sinetg_queue.sv
`default_nettype none

module sinetg_queue
  import sinetg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  frame_req_t wdata,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output frame_req_t rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_req_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sinetg_back.sv
`default_nettype none

module sinetg_back
  import sinetg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [2:0] sample_bytes,
  input  wire logic [1:0] channel_count,
  input  wire logic       q_not_empty,
  input  frame_req_t      q_rdata,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic            out_channel,
  output logic [1:0]      out_byte_index,
  output logic            out_last
);

  localparam logic [PROD_W:0] HALF_LSB = (PROD_W + 1)'(1) << 29;

  // table read stage
  logic  mag_v_r;
  mag_t  mag_r;
  logic  mag_neg_r;
  // product stage
  logic              prd_v_r;
  logic [PROD_W-1:0] prd_r;
  logic              prd_neg_r;
  // serialiser
  logic    ser_v_r;
  sample_t sval_r;
  logic    ch_r;
  logic [1:0] byte_r;

  logic [1:0] nb_m1;
  logic       nc_m1;
  mag_t       mxlev;
  logic       ser_load;
  logic       prd_take;
  logic       mag_take;
  logic       byte_last;
  logic [PROD_W:0] pos_sum;
  logic [PROD_W:0] neg_diff;
  sample_t    sval_nxt;

  always_comb begin
    case (sample_bytes)
      3'd0, 3'd1: nb_m1 = 2'd0;
      3'd2:       nb_m1 = 2'd1;
      3'd3:       nb_m1 = 2'd2;
      default:    nb_m1 = 2'd3;
    endcase
    nc_m1 = channel_count[1];
    case (nb_m1)
      2'd0:    mxlev = mag_t'(32'h0000_007F);
      2'd1:    mxlev = mag_t'(32'h0000_7FFF);
      2'd2:    mxlev = mag_t'(32'h007F_FFFF);
      default: mxlev = mag_t'(32'h7FFF_FFFF);
    endcase
  end

  assign byte_last = (byte_r == nb_m1);
  assign out_last  = byte_last && (ch_r == nc_m1);

  // stall chain: each stage loads when it is empty or is handing on
  assign ser_load = prd_v_r && (!ser_v_r || (out_ready && out_last));
  assign prd_take = !prd_v_r || ser_load;
  assign mag_take = !mag_v_r || prd_take;
  assign q_pop    = q_not_empty && mag_take;

  // magnitude +half LSB (-half if negative), truncated toward zero
  always_comb begin
    pos_sum  = {1'b0, prd_r} + HALF_LSB;
    neg_diff = {1'b0, prd_r} - HALF_LSB;
    if (!prd_neg_r) begin
      sval_nxt = pos_sum[61:30];
    end else if ({1'b0, prd_r} <= HALF_LSB) begin
      sval_nxt = '0;
    end else begin
      sval_nxt = '0 - neg_diff[61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (mag_take) begin
      mag_r     <= SINE_ROM[q_rdata.addr];
      mag_neg_r <= q_rdata.neg;
    end
    if (prd_take) begin
      prd_r     <= {{MAG_W{1'b0}}, mxlev} * {{MAG_W{1'b0}}, mag_r};
      prd_neg_r <= mag_neg_r;
    end
    if (ser_load) begin
      sval_r <= sval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_v_r <= 1'b0;
      prd_v_r <= 1'b0;
      ser_v_r <= 1'b0;
      ch_r    <= 1'b0;
      byte_r  <= 2'd0;
    end else begin
      if (mag_take) begin
        mag_v_r <= q_pop;
      end
      if (prd_take) begin
        prd_v_r <= mag_v_r;
      end
      if (ser_load) begin
        ser_v_r <= 1'b1;
        ch_r    <= 1'b0;
        byte_r  <= 2'd0;
      end else if (ser_v_r && out_ready) begin
        if (out_last) begin
          ser_v_r <= 1'b0;
        end else if (byte_last) begin
          byte_r <= 2'd0;
          ch_r   <= 1'b1;
        end else begin
          byte_r <= byte_r + 2'd1;
        end
      end
    end
  end

  assign out_valid      = ser_v_r;
  assign out_data_byte  = sval_r[8*byte_r +: 8];
  assign out_channel    = ch_r;
  assign out_byte_index = byte_r;

endmodule

`default_nettype wire

FILE: rtl/core/sine_tone_pcm_generator.sv
// Sine tone PCM generator: a phase accumulator NCO with a quarter-wave sine table.
// Input channel (in_valid/in_ready/in_restart): each word asks for one PCM frame;
// in_restart clears the phase before that frame is produced.
// Output channel (out_*): one word per sample byte, least significant byte first,
// channel 0 then channel 1, with out_last on the final byte of the frame.
// A frame has 1 to 8 words: sample_bytes clamped to 1..4, x2 if channel_count > 1.
// Configuration (cfg_we/cfg_index/cfg_data): write phase_step, sample_bytes and
// channel_count while the block is idle; writes take effect at once.
// A request passes from the queue through the table read, the multiply and the
// rounding into the serialiser before the first byte of its frame is offered.
// Throughput: one output word per cycle while out_ready holds and samples wait;
// the serialiser reloads as the last byte of a frame is taken, so a mono 8-bit
// stream runs at one frame per cycle under the same condition.
// When the receiver stalls, the serialiser holds its byte, the pipeline behind it
// fills, then the two-entry request queue fills and in_ready drops.
// Reset (synchronous, rst_n low): phase to zero, registers to a 440 Hz step at
// 44.1 kHz, 16-bit stereo; all queued and in-flight frames are dropped.
`default_nettype none

module sine_tone_pcm_generator
  import sinetg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_data_byte,
  output logic             out_channel,
  output logic [1:0]       out_byte_index,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] phase_step_r;
  logic [2:0]  sample_bytes_r;
  logic [1:0]  channel_count_r;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  frame_req_t q_wdata;
  frame_req_t q_rdata;

  // Configuration registers; an index past the map is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= 32'd42852281;
      sample_bytes_r  <= 3'd2;
      channel_count_r <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_STEP:    phase_step_r    <= cfg_data;
        CFG_SAMPLE_BYTES:  sample_bytes_r  <= cfg_data[2:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Front: take requests, advance the phase, turn it into table address and sign
  sinetg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .phase_step (phase_step_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // Short queue so that front and back stall on their own
  sinetg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // Back: table read, scale, round, split into bytes
  sinetg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_bytes   (sample_bytes_r),
    .channel_count  (channel_count_r),
    .q_not_empty    (q_not_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_channel    (out_channel),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
